// ===== src/svpwm_pkg.sv =====
// Package for the SVPWM duty generator: data sizes, register codes, sine table.
// No dependencies; the core takes every name by scoped reference.
package svpwm_pkg;

  localparam int SINE_TABLE_DEPTH = 256;
  localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SQRT3_HALF_Q15   = 28378;
  localparam int DIV_STEPS        = 16;
  localparam int FRONT_STAGES     = 11;
  localparam int LATENCY          = FRONT_STAGES + DIV_STEPS + 1;

  localparam logic [1:0] REG_VOLTAGE_LIMIT = 2'd0;
  localparam logic [1:0] REG_PWM_PERIOD    = 2'd1;

  localparam logic [15:0] VOLTAGE_LIMIT_RESET = 16'd65535;
  localparam logic [15:0] PWM_PERIOD_RESET    = 16'd1000;

  typedef logic [16:0] sine_table_t [0:SINE_TABLE_DEPTH];

  typedef struct packed {
    logic [15:0] vbus;
    logic        fault;
    logic [2:0]  sat;
  } side_t;

  // Quarter-wave sine, Q15, built from a Q30 series at elaboration.
  function automatic sine_table_t build_sine_table();
    sine_table_t tbl;
    logic [63:0] x;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] v;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x = (64'(i) * 64'd1686629713) / SINE_TABLE_DEPTH;
      sum = x;
      term = x;
      for (int k = 1; k <= 6; k++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      v = (sum + 64'd16384) >> 15;
      if (v > 64'd32768) v = 64'd32768;
      tbl[i] = v[16:0];
    end
    return tbl;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

  // Signed Q15 sine of a 16-bit angle by quadrant symmetry.
  function automatic logic signed [17:0] sine_of(input logic [15:0] angle);
    logic [13:0] r;
    logic [14+SINE_IDX_W-1:0] prod;
    logic [SINE_IDX_W-1:0] idx;
    logic [16:0] mag;
    r = angle[13:0];
    prod = (14+SINE_IDX_W)'(r) * (14+SINE_IDX_W)'(SINE_TABLE_DEPTH)
         + (14+SINE_IDX_W)'(8192);
    idx = prod[14+SINE_IDX_W-1:14];
    if (idx > SINE_IDX_W'(SINE_TABLE_DEPTH)) idx = SINE_IDX_W'(SINE_TABLE_DEPTH);
    if (angle[14]) mag = SINE_TABLE[SINE_TABLE_DEPTH - int'(idx)];
    else mag = SINE_TABLE[idx];
    if (angle[15]) return -$signed({1'b0, mag});
    return $signed({1'b0, mag});
  endfunction

endpackage

// ===== src/svpwm_duty_generator_core.sv =====
// SVPWM duty generator core: inverse Park, midpoint injection, clamp, divide.
// Depends on svpwm_pkg (sine table, register codes, stage counts).
//
//  channel | direction | handshake          | payload
//  s_axis  | in        | s_tvalid/s_tready  | s_tdata: d, q, rotor_angle, bus_voltage
//  m_axis  | out       | m_tvalid/m_tready  | m_tdata: compare a, b, c; m_tuser: bus_fault
//  cfg     | in        | cfg_valid/cfg_ready| cfg_addr register index, cfg_data value
//
// One request per cycle enters while the output is not stalled; each result passes through 11 arithmetic
// stages, 16 restoring divide steps and one output register.
// Sustained rate is one item per clock while the output is not stalled, set by the fully pipelined divider.
// Reset clears the valid bits and loads register defaults; data needs no reset.
// A stall at the output freezes every stage at once, so nothing is lost or repeated.
module svpwm_duty_generator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // d_voltage, q_voltage, rotor_angle, bus_voltage
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // compare_a, compare_b, compare_c
  output logic        m_tuser,  // bus_fault
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  localparam int LAT = svpwm_pkg::LATENCY;
  localparam int NDIV = svpwm_pkg::DIV_STEPS;
  localparam int FS = svpwm_pkg::FRONT_STAGES;

  logic [15:0] voltage_limit;
  logic [15:0] pwm_period;

  logic             vld  [0:LAT-1];
  svpwm_pkg::side_t side [0:LAT-1];
  logic             advance;

  // stage 1..11 data
  logic signed [15:0] s1_d, s1_q;
  logic signed [17:0] s1_s, s1_c;
  logic signed [33:0] s2_cd, s2_sq, s2_sd, s2_cq;
  logic signed [32:0] s3_ual, s3_ube;
  logic signed [47:0] s4_ua, s4_ual14, s4_ubek;
  logic signed [47:0] s5_u [0:2];
  logic signed [47:0] s6_u [0:2];
  logic signed [47:0] s6_mx, s6_mn;
  logic signed [47:0] s7_u [0:2];
  logic signed [49:0] s7_mid;
  logic signed [51:0] s8_p [0:2];
  logic [46:0]        s9_p [0:2];
  logic [39:0]        s10_ph [0:2];
  logic [38:0]        s10_pl [0:2];
  logic [31:0]        s11_n [0:2];

  // divider steps
  logic [31:0] div_rem [0:NDIV-1][0:2];
  logic [15:0] div_quo [0:NDIV-1][0:2];
  logic [31:0] rem_in  [0:NDIV-1][0:2];
  logic [15:0] quo_in  [0:NDIV-1][0:2];
  logic [31:0] rem_nx  [0:NDIV-1][0:2];
  logic [15:0] quo_nx  [0:NDIV-1][0:2];

  logic [47:0] out_data;
  logic        out_fault;

  logic signed [48:0] ubek_full;
  logic signed [51:0] p_wide [0:2];
  logic [62:0]        n_sum  [0:2];
  logic [46:0]        lim_w, full_w;

  assign advance   = !vld[LAT-1] || m_tready;
  assign s_tready  = advance;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = vld[LAT-1];
  assign m_tdata   = out_data;
  assign m_tuser   = out_fault;

  assign ubek_full = s3_ube * $signed(16'(svpwm_pkg::SQRT3_HALF_Q15));
  assign lim_w  = {voltage_limit, 31'd0};
  assign full_w = {side[7].vbus, 31'd0};

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      p_wide[l] = ($signed(52'(s7_u[l])) <<< 1) - $signed(52'(s7_mid));
      n_sum[l]  = ({23'd0, s10_ph[l]} << 23) + {24'd0, s10_pl[l]};
    end
    for (int k = 0; k < NDIV; k++) begin
      for (int l = 0; l < 3; l++) begin
        if (k == 0) begin
          rem_in[k][l] = s11_n[l];
          quo_in[k][l] = '0;
        end else begin
          rem_in[k][l] = div_rem[k-1][l];
          quo_in[k][l] = div_quo[k-1][l];
        end
        rem_nx[k][l] = rem_in[k][l];
        quo_nx[k][l] = quo_in[k][l];
        if (rem_in[k][l] >= ({16'd0, side[FS+k-1].vbus} << (NDIV-1-k))) begin
          rem_nx[k][l] = rem_in[k][l] - ({16'd0, side[FS+k-1].vbus} << (NDIV-1-k));
          quo_nx[k][l][NDIV-1-k] = 1'b1;
        end
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_limit <= svpwm_pkg::VOLTAGE_LIMIT_RESET;
      pwm_period    <= svpwm_pkg::PWM_PERIOD_RESET;
    end else if (cfg_valid) begin
      case (cfg_addr)
        svpwm_pkg::REG_VOLTAGE_LIMIT: voltage_limit <= cfg_data;
        svpwm_pkg::REG_PWM_PERIOD:    pwm_period    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits: advance all stages together.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LAT; i++) vld[i] <= 1'b0;
    end else if (advance) begin
      vld[0] <= s_tvalid;
      for (int i = 1; i < LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (advance) begin
      // stage 1: unpack, table lookups
      s1_d <= $signed(s_tdata[15:0]);
      s1_q <= $signed(s_tdata[31:16]);
      s1_s <= svpwm_pkg::sine_of(s_tdata[47:32]);
      s1_c <= svpwm_pkg::sine_of(s_tdata[47:32] + 16'd16384);
      side[0].vbus  <= s_tdata[63:48];
      side[0].fault <= (s_tdata[63:48] == 16'd0);
      side[0].sat   <= '0;
      // stage 9 side data is loaded below together with its saturation flags
      for (int i = 1; i < LAT; i++) begin
        if (i != 8) side[i] <= side[i-1];
      end
      // stage 2: products
      s2_cd <= s1_c * s1_d;
      s2_sq <= s1_s * s1_q;
      s2_sd <= s1_s * s1_d;
      s2_cq <= s1_c * s1_q;
      // stage 3: alpha / beta
      s3_ual <= 33'(s2_cd - s2_sq);
      s3_ube <= 33'(s2_sd + s2_cq);
      // stage 4: scale for phase projection
      s4_ua    <= $signed(48'(s3_ual)) <<< 15;
      s4_ual14 <= $signed(48'(s3_ual)) <<< 14;
      s4_ubek  <= 48'(ubek_full);
      // stage 5: three phases
      s5_u[0] <= s4_ua;
      s5_u[1] <= s4_ubek - s4_ual14;
      s5_u[2] <= -s4_ual14 - s4_ubek;
      // stage 6: max and min
      s6_u <= s5_u;
      s6_mx <= s5_u[0];
      s6_mn <= s5_u[0];
      if (s5_u[1] > s5_u[0] && s5_u[1] >= s5_u[2]) s6_mx <= s5_u[1];
      else if (s5_u[2] > s5_u[0] && s5_u[2] > s5_u[1]) s6_mx <= s5_u[2];
      if (s5_u[1] < s5_u[0] && s5_u[1] <= s5_u[2]) s6_mn <= s5_u[1];
      else if (s5_u[2] < s5_u[0] && s5_u[2] < s5_u[1]) s6_mn <= s5_u[2];
      // stage 7: midpoint minus half bus (Q31)
      s7_u <= s6_u;
      s7_mid <= $signed(50'(s6_mx)) + $signed(50'(s6_mn))
              - $signed({4'd0, side[5].vbus, 30'd0});
      // stage 8: centered phases
      s8_p <= p_wide;
      // stage 9: clamp, saturation flag
      side[8].vbus  <= side[7].vbus;
      side[8].fault <= side[7].fault;
      for (int l = 0; l < 3; l++) begin
        if (s8_p[l] < 0) s9_p[l] <= '0;
        else if (s8_p[l] > $signed({5'd0, lim_w})) s9_p[l] <= lim_w;
        else s9_p[l] <= s8_p[l][46:0];
        if (s8_p[l] >= 0 && s8_p[l] >= $signed({5'd0, full_w})
            && $signed({5'd0, lim_w}) >= $signed({5'd0, full_w}))
          side[8].sat[l] <= 1'b1;
        else if (s8_p[l] >= 0 && s8_p[l] > $signed({5'd0, lim_w})
                 && lim_w >= full_w)
          side[8].sat[l] <= 1'b1;
        else
          side[8].sat[l] <= 1'b0;
      end
      // stage 10: partial products with the period
      for (int l = 0; l < 3; l++) begin
        s10_ph[l] <= {16'd0, s9_p[l][46:23]} * {24'd0, pwm_period};
        s10_pl[l] <= {16'd0, s9_p[l][22:0]} * {23'd0, pwm_period};
      end
      // stage 11: sum, drop 31 fraction bits
      for (int l = 0; l < 3; l++) s11_n[l] <= n_sum[l][62:31];
      // divide steps
      div_rem <= rem_nx;
      div_quo <= quo_nx;
      // output register
      out_fault <= side[LAT-2].fault;
      for (int l = 0; l < 3; l++) begin
        if (side[LAT-2].fault) out_data[16*l +: 16] <= '0;
        else if (side[LAT-2].sat[l]) out_data[16*l +: 16] <= pwm_period;
        else out_data[16*l +: 16] <= div_quo[NDIV-1][l];
      end
    end
  end

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 48'd0)
    else $error("fault result carries nonzero compares");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready out of step with output stall");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tuser))
    else $error("stalled result dropped");

endmodule

// ===== sim/svpwm_duty_generator_core_test.sv =====
// Self-checking bench for svpwm_duty_generator_core: directed table, then random requests.
// Depends on svpwm_pkg (register codes, latency) and the core RTL; predicts each result not given by hand.
module svpwm_duty_generator_core_test;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // d_voltage, q_voltage, rotor_angle, bus_voltage
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // compare_a, compare_b, compare_c
  logic        m_tuser;   // bus_fault
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_data;

  typedef struct packed {
    logic [15:0] vbus;
    logic [15:0] angle;
    logic [15:0] q;
    logic [15:0] d;
  } dq_request_t;

  typedef struct {
    logic [15:0] cmp_a;
    logic [15:0] cmp_b;
    logic [15:0] cmp_c;
    logic        fault;
  } compare_set_t;

  typedef struct {
    dq_request_t  req;
    logic         typed;   // row carries a hand-written result
    compare_set_t want;
  } stim_row_t;

  svpwm_duty_generator_core dut (.*);

  // Bench copy of the registers.
  logic [15:0] limit_shadow;
  logic [15:0] period_shadow;
  longint      quarter_sine [0:256];

  compare_set_t pending_compares [$];
  bit          failed;
  longint      cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hang guard: slowest run is ~700 requests with random stalls on both sides and clearing gaps.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 200000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Quarter-wave table, Q15, from the same Q30 series the block is defined by.
  task automatic fill_sine();
    longint unsigned x, sum, term, v;
    for (int i = 0; i <= 256; i++) begin
      x = (longint'(i) * 64'd1686629713) / 256;
      sum = x;
      term = x;
      for (int k = 1; k <= 6; k++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / ((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum -= term;
        else sum += term;
      end
      v = (sum + 16384) >> 15;
      if (v > 32768) v = 32768;
      quarter_sine[i] = longint'(v);
    end
  endtask

  function automatic longint angle_sine(logic [15:0] ang);
    longint idx, mag;
    idx = (longint'(ang[13:0]) * 256 + 8192) >> 14;
    if (idx > 256) idx = 256;
    mag = ang[14] ? quarter_sine[256 - idx] : quarter_sine[idx];
    return ang[15] ? -mag : mag;
  endfunction

  function automatic logic [15:0] phase_count(longint p, longint lim, longint full);
    longint unsigned prod;
    if (p < 0) p = 0;
    if (p > lim) p = lim;
    if (p >= full) return period_shadow;
    // p < 2^47, period < 2^16: product fits in 64 bits
    prod = longint'(p) * longint'(period_shadow);
    return 16'(prod / longint'(full));
  endfunction

  function automatic compare_set_t predict_compares(dq_request_t r);
    compare_set_t res;
    longint d, q, s, c, al, be, ua, ub, uc, mx, mn, mid, lim, full;
    res = '{16'd0, 16'd0, 16'd0, 1'b1};
    if (r.vbus == 16'd0) return res;
    d = longint'($signed(r.d));
    q = longint'($signed(r.q));
    s = angle_sine(r.angle);
    c = angle_sine(r.angle + 16'd16384);
    al = c * d - s * q;
    be = s * d + c * q;
    ua = al * 32768;
    ub = -al * 16384 + be * svpwm_pkg::SQRT3_HALF_Q15;
    uc = -al * 16384 - be * svpwm_pkg::SQRT3_HALF_Q15;
    mx = ua; mn = ua;
    if (ub > mx) mx = ub;
    if (uc > mx) mx = uc;
    if (ub < mn) mn = ub;
    if (uc < mn) mn = uc;
    mid = (mx + mn) - longint'(r.vbus) * 64'sd1073741824;
    lim = longint'(limit_shadow) * 64'sd2147483648;
    full = longint'(r.vbus) * 64'sd2147483648;
    res.cmp_a = phase_count(2 * ua - mid, lim, full);
    res.cmp_b = phase_count(2 * ub - mid, lim, full);
    res.cmp_c = phase_count(2 * uc - mid, lim, full);
    res.fault = 1'b0;
    return res;
  endfunction

  // Write one register at a quiet moment; mirror it when the index is known.
  task automatic write_register(logic [1:0] addr, logic [15:0] value);
    cfg_addr  <= addr;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (addr == svpwm_pkg::REG_VOLTAGE_LIMIT) limit_shadow = value;
    else if (addr == svpwm_pkg::REG_PWM_PERIOD) period_shadow = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drain every outstanding result, then let the pipe settle.
  task automatic wait_quiet();
    while (pending_compares.size() != 0) @(negedge clk);
    repeat (svpwm_pkg::LATENCY + 4) @(negedge clk);
  endtask

  // Send one request, queue its expectation, then hold off a random gap.
  task automatic send_request(dq_request_t r, bit typed, compare_set_t want);
    compare_set_t exp_res;
    int gap;
    exp_res = typed ? want : predict_compares(r);
    s_tdata  <= r;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_compares.push_back(exp_res);
    gap = (($urandom % 4) == 0) ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic dq_request_t random_request();
    dq_request_t r;
    r = dq_request_t'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0: r.vbus = 16'd0;
      1: r.vbus = 16'($urandom_range(1, 16));
      2: r.vbus = 16'hFFFF;
      3: begin
        r.d = 16'($signed(16'($urandom_range(0, 600))) - 16'sd300);
        r.q = 16'($signed(16'($urandom_range(0, 600))) - 16'sd300);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Result side: random stalls, compare against oldest expectation.
  initial begin
    compare_set_t exp_res;
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = (($urandom % 4) == 0) ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (pending_compares.size() == 0) begin
        $error("result %h/%b arrived with nothing expected", m_tdata, m_tuser);
        failed = 1'b1;
      end else begin
        exp_res = pending_compares.pop_front();
        if (m_tdata[15:0] !== exp_res.cmp_a) begin
          $error("compare_a expected %0d actual %0d", exp_res.cmp_a, m_tdata[15:0]);
          failed = 1'b1;
        end
        if (m_tdata[31:16] !== exp_res.cmp_b) begin
          $error("compare_b expected %0d actual %0d", exp_res.cmp_b, m_tdata[31:16]);
          failed = 1'b1;
        end
        if (m_tdata[47:32] !== exp_res.cmp_c) begin
          $error("compare_c expected %0d actual %0d", exp_res.cmp_c, m_tdata[47:32]);
          failed = 1'b1;
        end
        if (m_tuser !== exp_res.fault) begin
          $error("bus_fault expected %0b actual %0b", exp_res.fault, m_tuser);
          failed = 1'b1;
        end
      end
      @(negedge clk);
    end
  end

  stim_row_t directed_rows [$];
  compare_set_t none_typed;

  initial begin
    dq_request_t r;
    logic [15:0] limits [4];
    logic [15:0] periods [4];
    failed = 1'b0;
    none_typed = '{16'd0, 16'd0, 16'd0, 1'b0};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_addr = svpwm_pkg::REG_VOLTAGE_LIMIT;
    cfg_data = '0;
    limit_shadow = svpwm_pkg::VOLTAGE_LIMIT_RESET;
    period_shadow = svpwm_pkg::PWM_PERIOD_RESET;
    fill_sine();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed table. Zero bus gives zero compares and the fault flag; zero command
    // centers every phase at half bus -> duty one half.
    directed_rows = '{
      '{'{16'd0, 16'd0, 16'd0, 16'd0}, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b1}},
      '{'{16'd0, 16'h4000, 16'h7FFF, 16'h8000}, 1'b1, '{16'd0, 16'd0, 16'd0, 1'b1}},
      '{'{16'd100, 16'd0, 16'd0, 16'd0}, 1'b1, '{16'd500, 16'd500, 16'd500, 1'b0}},
      '{'{16'hFFFF, 16'd0, 16'd0, 16'd0}, 1'b1, '{16'd500, 16'd500, 16'd500, 1'b0}},
      '{'{16'd1, 16'hFFFF, 16'h7FFF, 16'h7FFF}, 1'b0, none_typed},
      '{'{16'd1, 16'h0000, 16'h8000, 16'h8000}, 1'b0, none_typed},
      '{'{16'd1, 16'hC000, 16'h7FFF, 16'h8000}, 1'b0, none_typed},
      '{'{16'd1, 16'h8000, 16'h0000, 16'h7FFF}, 1'b0, none_typed},
      '{'{16'd100, 16'h2000, 16'h0100, 16'h0200}, 1'b0, none_typed},
      '{'{16'd100, 16'h6000, 16'hFF00, 16'hFE00}, 1'b0, none_typed},
      '{'{16'd100, 16'hA000, 16'h0000, 16'h0040}, 1'b0, none_typed},
      '{'{16'd100, 16'hE000, 16'h0000, 16'hFFC0}, 1'b0, none_typed},
      '{'{16'd10, 16'h3FFF, 16'd50, 16'd0}, 1'b0, none_typed},
      '{'{16'd10, 16'h5555, 16'hFFCE, 16'd0}, 1'b0, none_typed},
      '{'{16'hFFFF, 16'h1234, 16'd30000, 16'd30000}, 1'b0, none_typed}
    };
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    s_tvalid <= 1'b0;
    wait_quiet();

    // Phases walk through register settings, extremes included; an unused index too.
    limits  = '{16'd0, 16'd300, 16'hFFFF, 16'd40};
    periods = '{16'd0, 16'd1, 16'hFFFF, 16'd1000};
    for (int ph = 0; ph < 5; ph++) begin
      if (ph < 4) begin
        write_register(svpwm_pkg::REG_VOLTAGE_LIMIT, limits[ph]);
        write_register(svpwm_pkg::REG_PWM_PERIOD, periods[ph]);
      end else begin
        write_register(REG_UNUSED, 16'h5A5A);
        write_register(svpwm_pkg::REG_PWM_PERIOD, 16'd20000);
      end
      for (int n = 0; n < 130; n++) begin
        r = random_request();
        send_request(r, 1'b0, none_typed);
        // Pressure: once a phase, hold the sender until all results are back.
        if (n == 60) begin
          s_tvalid <= 1'b0;
          while (pending_compares.size() != 0) @(negedge clk);
        end
      end
      s_tvalid <= 1'b0;
      wait_quiet();
    end

    if (!failed && pending_compares.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/svpwm_pkg.sv
src/svpwm_duty_generator_core.sv
sim/svpwm_duty_generator_core_test.sv
